/* hw/rtl/hrsp_pkg.sv */
// ----------------------------------------------------------------------------
// hrsp_pkg
// shared constants and types for the hid report size parser
// ----------------------------------------------------------------------------
package hrsp_pkg;

   localparam int unsigned SIZE_W   = 32;
   localparam int unsigned RSIZE_W  = 11;
   localparam int unsigned STATUS_W = 2;

   // short item prefix codes
   localparam logic [1:0] ITEM_TYPE_MAIN   = 2'd0;
   localparam logic [1:0] ITEM_TYPE_GLOBAL = 2'd1;
   localparam logic [3:0] TAG_INPUT        = 4'd8;
   localparam logic [3:0] TAG_OUTPUT       = 4'd9;
   localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;
   localparam logic [1:0] SIZE_CODE_FOUR   = 2'd3;
   localparam logic [2:0] FOUR_BYTES       = 3'd4;

   // supported report sizes
   localparam logic [SIZE_W-1:0] RPT_SIZE_64   = 32'd64;
   localparam logic [SIZE_W-1:0] RPT_SIZE_512  = 32'd512;
   localparam logic [SIZE_W-1:0] RPT_SIZE_1024 = 32'd1024;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SIZE_DIFFER = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNSUPPORTED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RESERVED    = 2'd3;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] in_size;
      logic [SIZE_W-1:0] out_size;
   } hrsp_sizes_type;

endpackage

/* hw/rtl/hrsp_item_decoder.sv */
// ----------------------------------------------------------------------------
// hrsp_item_decoder
// walks the descriptor byte stream, gathers report count, latches sizes
// ----------------------------------------------------------------------------
module hrsp_item_decoder
   import hrsp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           take,
   input  logic [7:0]     desc_byte,
   input  logic           last_byte,
   output hrsp_sizes_type sizes
);

   logic [SIZE_W-1:0] count_acc_ff, count_acc_in;
   logic [SIZE_W-1:0] in_size_ff, in_size_in;
   logic [SIZE_W-1:0] out_size_ff, out_size_in;
   logic [2:0]        bytes_left_ff, bytes_left_in;
   logic [1:0]        byte_pos_ff, byte_pos_in;
   logic              in_count_ff, in_count_in;

   logic [3:0] item_tag;
   logic [1:0] item_kind;
   logic [1:0] size_code;

   assign item_tag  = desc_byte[7:4];
   assign item_kind = desc_byte[3:2];
   assign size_code = desc_byte[1:0];

   always_comb begin
      count_acc_in  = count_acc_ff;
      in_size_in    = in_size_ff;
      out_size_in   = out_size_ff;
      bytes_left_in = bytes_left_ff;
      byte_pos_in   = byte_pos_ff;
      in_count_in   = in_count_ff;
      if (bytes_left_ff != 3'd0) begin
         // data byte, little-endian shift-in
         if (in_count_ff) begin
            count_acc_in = count_acc_ff | (SIZE_W'(desc_byte) << {byte_pos_ff, 3'b000});
         end
         byte_pos_in   = byte_pos_ff + 2'd1;
         bytes_left_in = bytes_left_ff - 3'd1;
      end else begin
         // prefix byte
         in_count_in = 1'b0;
         priority if (item_kind == ITEM_TYPE_GLOBAL && item_tag == TAG_REPORT_COUNT) begin
            count_acc_in = '0;
            in_count_in  = 1'b1;
         end else if (item_kind == ITEM_TYPE_MAIN && item_tag == TAG_INPUT) begin
            in_size_in = count_acc_ff;
         end else if (item_kind == ITEM_TYPE_MAIN && item_tag == TAG_OUTPUT) begin
            out_size_in = count_acc_ff;
         end else begin
            count_acc_in = count_acc_ff;
         end
         bytes_left_in = (size_code == SIZE_CODE_FOUR) ? FOUR_BYTES : {1'b0, size_code};
         byte_pos_in   = 2'd0;
      end
   end

   assign sizes.done     = take & last_byte;
   assign sizes.in_size  = in_size_in;
   assign sizes.out_size = out_size_in;

   always_ff @(posedge clock) begin
      if (reset || (take && last_byte)) begin
         count_acc_ff  <= '0;
         in_size_ff    <= '0;
         out_size_ff   <= '0;
         bytes_left_ff <= '0;
         byte_pos_ff   <= '0;
         in_count_ff   <= 1'b0;
      end else if (take) begin
         count_acc_ff  <= count_acc_in;
         in_size_ff    <= in_size_in;
         out_size_ff   <= out_size_in;
         bytes_left_ff <= bytes_left_in;
         byte_pos_ff   <= byte_pos_in;
         in_count_ff   <= in_count_in;
      end
   end

endmodule

/* hw/rtl/hrsp_result_stage.sv */
// ----------------------------------------------------------------------------
// hrsp_result_stage
// checks the latched sizes and holds the result word until it is taken
// ----------------------------------------------------------------------------
module hrsp_result_stage
   import hrsp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  hrsp_sizes_type      sizes,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [RSIZE_W-1:0]  rsp_rpt_size,
   output logic [STATUS_W-1:0] rsp_status
);

   logic                rsp_valid_ff;
   logic [RSIZE_W-1:0]  rpt_size_ff, rpt_size_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                supported;

   assign supported = (sizes.in_size == RPT_SIZE_64)
                   || (sizes.in_size == RPT_SIZE_512)
                   || (sizes.in_size == RPT_SIZE_1024);

   always_comb begin
      rpt_size_in = '0;
      priority if (sizes.in_size != sizes.out_size) begin
         status_in = STATUS_SIZE_DIFFER;
      end else if (!supported) begin
         status_in = STATUS_UNSUPPORTED;
      end else begin
         status_in   = STATUS_OK;
         rpt_size_in = sizes.in_size[RSIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (sizes.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (sizes.done) begin
         rpt_size_ff <= rpt_size_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rpt_size = rpt_size_ff;
   assign rsp_status   = status_ff;

endmodule

/* hw/rtl/hid_report_size_parser_core.sv */
// ----------------------------------------------------------------------------
// hid_report_size_parser_core
// report size detection over a hid report descriptor byte stream
// ----------------------------------------------------------------------------
// One descriptor byte is taken per cycle. The byte flagged last gives one
// result word in the next cycle: status ok with the report size, or a nonzero
// status with size 0. Bytes keep flowing while that word waits; the input
// stalls only while a result is held and the result side stalls. After the
// flagged byte the parser starts a fresh descriptor.
module hid_report_size_parser_core
   import hrsp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_desc_byte,
   input  logic                req_last_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [RSIZE_W-1:0]  rsp_rpt_size,
   output logic [STATUS_W-1:0] rsp_status
);

   hrsp_sizes_type sizes;
   logic           take;

   assign req_stall = rsp_valid & rsp_stall;
   assign take      = req_valid & ~req_stall;

   hrsp_item_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .desc_byte (req_desc_byte),
      .last_byte (req_last_byte),
      .sizes     (sizes)
   );

   hrsp_result_stage u_result (
      .clock        (clock),
      .reset        (reset),
      .sizes        (sizes),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_rpt_size (rsp_rpt_size),
      .rsp_status   (rsp_status)
   );

endmodule

/* hw/rtl/hrsp_checker.sv */
// ----------------------------------------------------------------------------
// hrsp_checker
// port-level checks for the hid report size parser
// ----------------------------------------------------------------------------
module hrsp_checker
   import hrsp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [7:0]          req_desc_byte,
   input  logic                req_last_byte,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [RSIZE_W-1:0]  rsp_rpt_size,
   input  logic [STATUS_W-1:0] rsp_status
);

   // last byte gives a word next cycle
   a_last_gives_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_byte |=> rsp_valid)
      else $error("no result word after last byte");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != STATUS_RESERVED)
      else $error("reserved status code");

   a_error_size_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_rpt_size == '0)
      else $error("nonzero size with error status");

   a_ok_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |->
         rsp_rpt_size == RSIZE_W'(64) || rsp_rpt_size == RSIZE_W'(512)
         || rsp_rpt_size == RSIZE_W'(1024))
      else $error("ok status with unsupported size");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rpt_size)
         && $stable(rsp_status))
      else $error("stalled result word changed");

endmodule

bind hid_report_size_parser_core hrsp_checker u_hrsp_checker (.*);

/* tb/hid_report_size_parser_core_test.sv */
// ----------------------------------------------------------------------------
// hid_report_size_parser_core_test
// self-checking bench for the hid report size parser core
// ----------------------------------------------------------------------------
// Descriptor byte streams are fed in, mostly well-formed descriptors with
// random report counts and filler items, some cut short, plus random noise.
// A scoreboard tracks the parser state per accepted word and predicts the
// size and status word per flagged last byte. Both sides idle at random in
// two phases; the third backs up input by one long result-side hold-off.
module hid_report_size_parser_core_test
   import hrsp_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   class size_scoreboard;
      logic [SIZE_W-1:0]   count_acc;
      logic [SIZE_W-1:0]   in_size;
      logic [SIZE_W-1:0]   out_size;
      logic [2:0]          bytes_left;
      logic [1:0]          byte_pos;
      logic                in_count;
      logic [RSIZE_W-1:0]  size_q[$];
      logic [STATUS_W-1:0] status_q[$];
      int                  errors;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         count_acc  = '0;
         in_size    = '0;
         out_size   = '0;
         bytes_left = '0;
         byte_pos   = '0;
         in_count   = 1'b0;
      endfunction

      function int pending();
         return size_q.size();
      endfunction

      function void note_word(logic [7:0] b, logic last);
         logic [3:0] tag;
         logic [1:0] kind;
         logic [1:0] code;
         tag  = b[7:4];
         kind = b[3:2];
         code = b[1:0];
         if (bytes_left != 3'd0) begin
            if (in_count)
               count_acc = count_acc | (SIZE_W'(b) << {byte_pos, 3'b000});
            byte_pos   = byte_pos + 2'd1;
            bytes_left = bytes_left - 3'd1;
         end else begin
            in_count = 1'b0;
            if (kind == ITEM_TYPE_GLOBAL && tag == TAG_REPORT_COUNT) begin
               count_acc = '0;
               in_count  = 1'b1;
            end else if (kind == ITEM_TYPE_MAIN && tag == TAG_INPUT) begin
               in_size = count_acc;
            end else if (kind == ITEM_TYPE_MAIN && tag == TAG_OUTPUT) begin
               out_size = count_acc;
            end
            bytes_left = (code == SIZE_CODE_FOUR) ? FOUR_BYTES : {1'b0, code};
            byte_pos   = 2'd0;
         end
         if (last) begin
            if (in_size != out_size) begin
               size_q.push_back('0);
               status_q.push_back(STATUS_SIZE_DIFFER);
            end else if (in_size != RPT_SIZE_64 && in_size != RPT_SIZE_512 &&
                         in_size != RPT_SIZE_1024) begin
               size_q.push_back('0);
               status_q.push_back(STATUS_UNSUPPORTED);
            end else begin
               size_q.push_back(in_size[RSIZE_W-1:0]);
               status_q.push_back(STATUS_OK);
            end
            clear();
         end
      endfunction

      function void check_word(logic [RSIZE_W-1:0] size, logic [STATUS_W-1:0] status);
         logic [RSIZE_W-1:0]  exp_size;
         logic [STATUS_W-1:0] exp_status;
         if (size_q.size() == 0) begin
            $error("unexpected result word: rpt_size %0d status %0d", size, status);
            errors++;
            return;
         end
         exp_size   = size_q.pop_front();
         exp_status = status_q.pop_front();
         if (size !== exp_size) begin
            $error("rpt_size: expected %0d, actual %0d", exp_size, size);
            errors++;
         end
         if (status !== exp_status) begin
            $error("status: expected %0d, actual %0d", exp_status, status);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [7:0]          req_desc_byte;
   logic                req_last_byte;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [RSIZE_W-1:0]  rsp_rpt_size;
   logic [STATUS_W-1:0] rsp_status;

   size_scoreboard board;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int words_sent;

   hid_report_size_parser_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_desc_byte (req_desc_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rpt_size  (rsp_rpt_size),
      .rsp_status    (rsp_status)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side stall, with an optional long hold-off
   initial begin
      rsp_stall = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word(rsp_rpt_size, rsp_status);
   end

   task automatic send_word(input logic [7:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_desc_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      board.note_word(b, last);
      words_sent++;
   endtask

   task automatic send_descriptor(input logic [7:0] desc[$]);
      foreach (desc[i])
         send_word(desc[i], i == desc.size() - 1);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [SIZE_W-1:0] pick_count();
      case ($urandom_range(7))
         0, 1:    return RPT_SIZE_64;
         2:       return RPT_SIZE_512;
         3:       return RPT_SIZE_1024;
         4:       return '0;
         5:       return $urandom;
         default: return $urandom_range(2000);
      endcase
   endfunction

   function automatic void push_item(ref logic [7:0] desc[$], input logic [3:0] tag,
                                     input logic [1:0] kind, input logic [SIZE_W-1:0] data);
      logic [1:0] code;
      int         n;
      if (data == 0 && $urandom_range(1))
         code = 2'd0;
      else if (data < 256)
         code = 2'($urandom_range(3, 1));
      else if (data < 65536)
         code = $urandom_range(1) ? 2'd2 : SIZE_CODE_FOUR;
      else
         code = SIZE_CODE_FOUR;
      desc.push_back({tag, kind, code});
      n = (code == SIZE_CODE_FOUR) ? 4 : int'(code);
      for (int i = 0; i < n; i++)
         desc.push_back(data[8*i +: 8]);
   endfunction

   function automatic void push_filler(ref logic [7:0] desc[$]);
      logic [7:0] prefix;
      int         n;
      prefix = 8'($urandom);
      desc.push_back(prefix);
      n = (prefix[1:0] == SIZE_CODE_FOUR) ? 4 : int'(prefix[1:0]);
      for (int i = 0; i < n; i++)
         desc.push_back(8'($urandom));
   endfunction

   function automatic void build_descriptor(ref logic [7:0] desc[$]);
      logic [SIZE_W-1:0] count;
      int                cut;
      desc.delete();
      if ($urandom_range(99) < 20) begin
         repeat ($urandom_range(12, 1)) desc.push_back(8'($urandom));
         return;
      end
      count = pick_count();
      if ($urandom_range(3) == 0) push_filler(desc);
      push_item(desc, TAG_REPORT_COUNT, ITEM_TYPE_GLOBAL, count);
      push_item(desc, TAG_INPUT, ITEM_TYPE_MAIN, $urandom_range(255));
      if ($urandom_range(2) == 0) push_filler(desc);
      if ($urandom_range(3) == 0) count = pick_count();
      if ($urandom_range(9) != 0)
         push_item(desc, TAG_REPORT_COUNT, ITEM_TYPE_GLOBAL, count);
      push_item(desc, TAG_OUTPUT, ITEM_TYPE_MAIN, $urandom_range(255));
      if ($urandom_range(3) == 0) push_filler(desc);
      // cut short, sometimes in the middle of an item
      if ($urandom_range(99) < 20) begin
         cut = $urandom_range(desc.size() - 1, 1);
         while (desc.size() > cut)
            void'(desc.pop_back());
      end
   endfunction

   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [7:0] desc[$];
      board          = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_desc_byte  = '0;
      req_last_byte  = 1'b0;
      send_idle_pct  = 23;
      recv_stall_pct = 59;
      hold_left      = 0;
      words_sent     = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      desc = '{8'h95, 8'h40, 8'h81, 8'h02, 8'h91, 8'h02};
      send_descriptor(desc);
      desc = '{8'h96, 8'h00, 8'h04, 8'h80, 8'h90};
      send_descriptor(desc);
      // input 512, then a count without data zeroes the output size
      desc = '{8'h97, 8'h00, 8'h02, 8'h00, 8'h00, 8'h80, 8'h94, 8'h90};
      send_descriptor(desc);
      desc = '{8'h95, 8'hff, 8'h80, 8'h90};
      send_descriptor(desc);
      desc = '{8'h97, 8'h12};
      send_descriptor(desc);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 23;
               recv_stall_pct = 59;
            end
            1: begin
               send_idle_pct  = 59;
               recv_stall_pct = 23;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               hold_left      = 80;
            end
         endcase
         while (words_sent < 135 * (phase + 1)) begin
            build_descriptor(desc);
            send_descriptor(desc);
         end
         drain();
      end

      if (board.errors == 0 && board.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
